FILE: hdl/pal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional array list package
// Widths, operation codes and status codes shared by the list block, its
// checker and the testbench; the storage does not import them.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int LIST_DEPTH = 256;
    localparam int ADDR_W     = 8;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = 9;
    localparam int FUNC_W     = 3;
    localparam int STATUS_W   = 2;

    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 48;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [CNT_W-1:0]    count_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic signed [DATA_W-1:0] word_t;

    localparam func_t OP_APPEND = 3'd0;
    localparam func_t OP_INSERT = 3'd1;
    localparam func_t OP_READ   = 3'd2;
    localparam func_t OP_WRITE  = 3'd3;
    localparam func_t OP_DELETE = 3'd4;
    localparam func_t OP_CLEAR  = 3'd5;

    localparam status_t ST_DONE   = 2'd0;
    localparam status_t ST_BADIDX = 2'd1;
    localparam status_t ST_FULL   = 2'd2;

    localparam count_t CAP_RESET = 9'd256;

endpackage

FILE: hdl/pal_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional array list RAM
// Generic simple dual-port RAM with one write port and one registered read
// port.
// ----------------------------------------------------------------------------
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/positional_array_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional array list
// Ordered list of signed 32-bit words held in one RAM, with append, insert,
// read, overwrite, delete and clear requests.
//
//   Channel   Direction  Handshake           Contents
//   s_        in         s_tvalid/s_tready   request: func, index, data
//   m_        out        m_tvalid/m_tready   result: read_data, status, count
//   cfg_      in         cfg_valid/cfg_ready capacity register
//
// Append, overwrite, clear, unused codes and failed requests go from the
// execute state to the result state, and a read passes through a RAM read
// wait state first. Insert and delete short of the end of the list move the
// entries behind the index one per cycle through the RAM read/write ports.
// A new request is accepted once the previous result
// has been loaded into the output register. Reset clears the list count and
// sets the capacity to 256; the RAM contents are not cleared.
// ----------------------------------------------------------------------------
module positional_array_list
    import pal_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // tdata: index[7:0], data[39:8]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // tuser: func[2:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata: read_data[31:0], status[33:32], item_total[42:34], is_empty[43],
    //        is_full[44], zero fill[47:45]
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [CNT_W-1:0]     cfg_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_UP     = 3'd2;
    localparam logic [2:0] S_FIN    = 3'd3;
    localparam logic [2:0] S_DN     = 3'd4;
    localparam logic [2:0] S_RDWAIT = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    logic [2:0] state_reg, state_next;
    count_t     count_reg, count_next;
    count_t     capacity_reg, capacity_next;
    logic       m_tvalid_reg, m_tvalid_next;

    func_t   func_reg, func_next;
    addr_t   idx_reg, idx_next;
    word_t   data_reg, data_next;
    addr_t   w_reg, w_next;
    status_t status_reg, status_next;
    word_t   rd_reg, rd_next;

    word_t   out_rd_reg, out_rd_next;
    status_t out_status_reg, out_status_next;
    count_t  out_total_reg, out_total_next;
    logic    out_empty_reg, out_empty_next;
    logic    out_full_reg, out_full_next;

    logic              mem_we;
    addr_t             mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    addr_t             mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    count_t cap_use;
    count_t idx_ext;
    count_t w_ext;
    logic   is_full_now;

    pal_ram #(
        .WIDTH (DATA_W),
        .DEPTH (LIST_DEPTH)
    ) u_pal_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb begin
        if (capacity_reg == '0) begin
            cap_use = count_t'(1);
        end else if (capacity_reg > count_t'(LIST_DEPTH)) begin
            cap_use = count_t'(LIST_DEPTH);
        end else begin
            cap_use = capacity_reg;
        end
    end

    assign idx_ext     = {1'b0, idx_reg};
    assign w_ext       = {1'b0, w_reg};
    assign is_full_now = (count_reg >= cap_use);

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {3'b000, out_full_reg, out_empty_reg, out_total_reg,
                        out_status_reg, out_rd_reg};

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        capacity_next   = capacity_reg;
        m_tvalid_next   = m_tvalid_reg;
        func_next       = func_reg;
        idx_next        = idx_reg;
        data_next       = data_reg;
        w_next          = w_reg;
        status_next     = status_reg;
        rd_next         = rd_reg;
        out_rd_next     = out_rd_reg;
        out_status_next = out_status_reg;
        out_total_next  = out_total_reg;
        out_empty_next  = out_empty_reg;
        out_full_next   = out_full_reg;
        mem_we          = 1'b0;
        mem_waddr       = w_reg;
        mem_wdata       = data_reg;
        mem_raddr       = w_reg;

        if (cfg_valid && cfg_ready) begin
            capacity_next = cfg_data;
        end
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    func_next   = s_tuser[FUNC_W-1:0];
                    idx_next    = s_tdata[ADDR_W-1:0];
                    data_next   = s_tdata[ADDR_W +: DATA_W];
                    status_next = ST_DONE;
                    rd_next     = '0;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_RESULT;
                unique case (func_reg)
                    OP_APPEND: begin
                        if (is_full_now) begin
                            status_next = ST_FULL;
                        end else begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[ADDR_W-1:0];
                            count_next = count_reg + 1'b1;
                        end
                    end
                    OP_INSERT: begin
                        if (idx_ext > count_reg) begin
                            status_next = ST_BADIDX;
                        end else if (is_full_now) begin
                            status_next = ST_FULL;
                        end else if (idx_ext == count_reg) begin
                            mem_we     = 1'b1;
                            mem_waddr  = idx_reg;
                            count_next = count_reg + 1'b1;
                        end else begin
                            mem_raddr  = addr_t'(count_reg - 1'b1);
                            w_next     = count_reg[ADDR_W-1:0];
                            state_next = S_UP;
                        end
                    end
                    OP_READ: begin
                        if (idx_ext >= count_reg) begin
                            status_next = ST_BADIDX;
                            rd_next     = '1;
                        end else begin
                            mem_raddr  = idx_reg;
                            state_next = S_RDWAIT;
                        end
                    end
                    OP_WRITE: begin
                        if (idx_ext >= count_reg) begin
                            status_next = ST_BADIDX;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = idx_reg;
                        end
                    end
                    OP_DELETE: begin
                        if (idx_ext >= count_reg) begin
                            status_next = ST_BADIDX;
                        end else if (idx_ext + 1'b1 == count_reg) begin
                            count_next = count_reg - 1'b1;
                        end else begin
                            mem_raddr  = idx_reg + 1'b1;
                            w_next     = idx_reg;
                            state_next = S_DN;
                        end
                    end
                    OP_CLEAR: begin
                        count_next = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_UP: begin
                mem_we    = 1'b1;
                mem_waddr = w_reg;
                mem_wdata = mem_rdata;
                if (w_ext == idx_ext + 1'b1) begin
                    state_next = S_FIN;
                end else begin
                    mem_raddr = w_reg - 2'd2;
                    w_next    = w_reg - 1'b1;
                end
            end
            S_FIN: begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                count_next = count_reg + 1'b1;
                state_next = S_RESULT;
            end
            S_DN: begin
                mem_we    = 1'b1;
                mem_waddr = w_reg;
                mem_wdata = mem_rdata;
                if (w_ext + 2'd2 == count_reg) begin
                    count_next = count_reg - 1'b1;
                    state_next = S_RESULT;
                end else begin
                    mem_raddr = w_reg + 2'd2;
                    w_next    = w_reg + 1'b1;
                end
            end
            S_RDWAIT: begin
                rd_next    = mem_rdata;
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_rd_next     = rd_reg;
                    out_status_next = status_reg;
                    out_total_next  = count_reg;
                    out_empty_next  = (count_reg == '0);
                    out_full_next   = is_full_now;
                    m_tvalid_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            capacity_reg <= CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            capacity_reg <= capacity_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        idx_reg        <= idx_next;
        data_reg       <= data_next;
        w_reg          <= w_next;
        status_reg     <= status_next;
        rd_reg         <= rd_next;
        out_rd_reg     <= out_rd_next;
        out_status_reg <= out_status_next;
        out_total_reg  <= out_total_next;
        out_empty_reg  <= out_empty_next;
        out_full_reg   <= out_full_next;
    end

endmodule

FILE: hdl/pal_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional array list checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pal_checker
    import pal_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready
);

    logic [DATA_W-1:0]   rd_w;
    logic [STATUS_W-1:0] st_w;
    logic [CNT_W-1:0]    total_w;

    assign rd_w    = m_tdata[DATA_W-1:0];
    assign st_w    = m_tdata[DATA_W +: STATUS_W];
    assign total_w = m_tdata[DATA_W+STATUS_W +: CNT_W];

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result transaction changed");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[DATA_W+STATUS_W+CNT_W] == (total_w == '0)))
        else $error("empty flag disagrees with count");

    a_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (st_w != 2'd3) && (total_w <= CNT_W'(LIST_DEPTH)))
        else $error("status code or count out of range");

    a_fail_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st_w != ST_DONE) |-> (rd_w == '0) || (rd_w == '1))
        else $error("failed request returned entry data");

endmodule

bind positional_array_list pal_checker u_pal_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional array list testbench
// Drives list requests into the block and checks every result against a
// behavioral model of the list kept in this bench. Directed tests cover the
// empty list, the value extremes, the unused operation codes and the capacity
// corner cases. A fill test takes the list to full depth. A stall test holds
// the result channel off long enough for the request channel to back up.
// Random phases then run under a range of capacity settings, with random
// idle bursts on both channels in most phases.
// ----------------------------------------------------------------------------
module tb_top;
    import pal_pkg::*;

    localparam int    CYCLE_LIMIT = 1500000;
    localparam int    HOLD_CYCLES = 400;
    localparam int    DRAIN_CYCLES = 300;
    localparam func_t OP_SPARE_A = 3'd6;
    localparam func_t OP_SPARE_B = 3'd7;

    typedef struct packed {
        word_t   read_data;
        status_t status;
        count_t  item_total;
        logic    is_empty;
        logic    is_full;
    } list_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [CNT_W-1:0]     cfg_data;
    logic                 cfg_valid;
    logic                 cfg_ready;

    word_t        list_mem [LIST_DEPTH];
    int           list_count;
    count_t       cap_reg;
    list_result_t pending_results [$];
    list_result_t expected_now;
    int           error_count = 0;
    int           cycle_count = 0;
    bit           idle_on = 1'b0;
    int           hold_token = 0;
    int           hold_seen = 0;
    int           rx_hold = 0;
    int           rx_gap = 0;

    positional_array_list dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic list_result_t apply_list_op(func_t f, addr_t idx, word_t d);
        list_result_t r;
        int           n;
        int           cap;
        int           pos;
        int           i;
        logic         full;
        cap = int'(cap_reg);
        if (cap == 0) cap = 1;
        if (cap > LIST_DEPTH) cap = LIST_DEPTH;
        n = list_count;
        pos = int'(idx);
        full = (n >= cap);
        r.read_data = '0;
        r.status = ST_DONE;
        case (f)
            OP_APPEND: begin
                if (full) begin
                    r.status = ST_FULL;
                end else begin
                    list_mem[n] = d;
                    n++;
                end
            end
            OP_INSERT: begin
                if (pos > n) begin
                    r.status = ST_BADIDX;
                end else if (full) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = n; i > pos; i--) list_mem[i] = list_mem[i-1];
                    list_mem[pos] = d;
                    n++;
                end
            end
            OP_READ: begin
                if (pos >= n) begin
                    r.status = ST_BADIDX;
                    r.read_data = -1;
                end else begin
                    r.read_data = list_mem[pos];
                end
            end
            OP_WRITE: begin
                if (pos >= n) r.status = ST_BADIDX;
                else list_mem[pos] = d;
            end
            OP_DELETE: begin
                if (pos >= n) begin
                    r.status = ST_BADIDX;
                end else begin
                    for (i = pos; i + 1 < n; i++) list_mem[i] = list_mem[i+1];
                    n--;
                end
            end
            OP_CLEAR: n = 0;
            default: ;
        endcase
        list_count = n;
        r.item_total = count_t'(n);
        r.is_empty = (n == 0);
        r.is_full = (n >= cap);
        return r;
    endfunction

    task automatic issue_request(input func_t f, input addr_t idx, input word_t d);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tdata = {d, idx};
        s_tuser = f;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_list_op(f, idx, d));
    endtask

    task automatic wait_list_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_capacity(input count_t value);
        wait_list_idle();
        @(negedge aclk);
        cfg_data = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cap_reg = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic func_t pick_func();
        int r;
        r = $urandom_range(0, 99);
        if (r < 28) return OP_APPEND;
        if (r < 50) return OP_INSERT;
        if (r < 68) return OP_READ;
        if (r < 82) return OP_WRITE;
        if (r < 96) return OP_DELETE;
        if (r < 98) return OP_CLEAR;
        return ($urandom_range(0, 1) == 0) ? OP_SPARE_A : OP_SPARE_B;
    endfunction

    function automatic addr_t pick_index(func_t f);
        if (list_count > 0 && $urandom_range(0, 9) < 8) begin
            if (f == OP_INSERT) return addr_t'($urandom_range(0, list_count));
            return addr_t'($urandom_range(0, list_count - 1));
        end
        return addr_t'($urandom_range(0, 255));
    endfunction

    task automatic issue_random_requests(input int count);
        func_t f;
        for (int k = 0; k < count; k++) begin
            f = pick_func();
            issue_request(f, pick_index(f), word_t'($urandom));
        end
    endtask

    // Result channel: random stall bursts, plus one long hold-off on request.
    always @(negedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            rx_hold = HOLD_CYCLES;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready = 1'b0;
        end else if (!idle_on) begin
            m_tready = 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready = 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            rx_gap = $urandom_range(0, 14);
            m_tready = 1'b0;
        end else begin
            m_tready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result transaction %h", $realtime, m_tdata);
            end else begin
                expected_now = pending_results.pop_front();
                if ($signed(m_tdata[31:0]) != expected_now.read_data) begin
                    error_count++;
                    $display("%0t: read_data expected %0d actual %0d", $realtime,
                             expected_now.read_data, $signed(m_tdata[31:0]));
                end
                if (m_tdata[33:32] != expected_now.status) begin
                    error_count++;
                    $display("%0t: status expected %0d actual %0d", $realtime,
                             expected_now.status, m_tdata[33:32]);
                end
                if (m_tdata[42:34] != expected_now.item_total) begin
                    error_count++;
                    $display("%0t: item_total expected %0d actual %0d", $realtime,
                             expected_now.item_total, m_tdata[42:34]);
                end
                if (m_tdata[43] != expected_now.is_empty) begin
                    error_count++;
                    $display("%0t: is_empty expected %0d actual %0d", $realtime,
                             expected_now.is_empty, m_tdata[43]);
                end
                if (m_tdata[44] != expected_now.is_full) begin
                    error_count++;
                    $display("%0t: is_full expected %0d actual %0d", $realtime,
                             expected_now.is_full, m_tdata[44]);
                end
            end
        end
    end

    task automatic test_basic_ops();
        idle_on = 1'b1;
        issue_request(OP_READ, 8'd0, 32'sd0);
        issue_request(OP_DELETE, 8'd0, 32'sd0);
        issue_request(OP_WRITE, 8'd0, 32'sd1);
        issue_request(OP_INSERT, 8'd1, 32'sd2);
        issue_request(OP_INSERT, 8'd0, 32'sh7FFFFFFF);
        issue_request(OP_APPEND, 8'd0, 32'sh80000000);
        issue_request(OP_INSERT, 8'd1, -32'sd1);
        issue_request(OP_READ, 8'd1, 32'sd0);
        issue_request(OP_WRITE, 8'd2, 32'sd0);
        issue_request(OP_READ, 8'd255, 32'sd0);
        issue_request(OP_DELETE, 8'd2, 32'sd0);
        issue_request(OP_DELETE, 8'd0, 32'sd0);
        issue_request(OP_SPARE_A, 8'd255, -32'sd1);
        issue_request(OP_SPARE_B, 8'd0, 32'sd0);
        issue_request(OP_CLEAR, 8'd0, 32'sd0);
        wait_list_idle();
    endtask

    task automatic test_capacity_corners();
        write_capacity(9'd1);
        issue_request(OP_APPEND, 8'd0, 32'sd5);
        issue_request(OP_APPEND, 8'd0, 32'sd6);
        issue_request(OP_INSERT, 8'd0, 32'sd7);
        issue_request(OP_INSERT, 8'd5, 32'sd8);
        // A capacity of zero behaves as one.
        write_capacity(9'd0);
        issue_request(OP_APPEND, 8'd0, 32'sd9);
        // Values above the store depth are limited to the depth.
        write_capacity(9'd511);
        issue_request(OP_APPEND, 8'd0, 32'sd10);
        issue_request(OP_APPEND, 8'd0, 32'sd11);
        // Lowering the capacity below the count keeps the list intact.
        write_capacity(9'd2);
        issue_request(OP_APPEND, 8'd0, 32'sd12);
        issue_request(OP_DELETE, 8'd0, 32'sd0);
        issue_request(OP_READ, 8'd1, 32'sd0);
        wait_list_idle();
    endtask

    task automatic test_fill_to_depth();
        write_capacity(CAP_RESET);
        issue_request(OP_CLEAR, 8'd0, 32'sd0);
        for (int k = 0; k < LIST_DEPTH; k++) issue_request(OP_APPEND, 8'd0, word_t'($urandom));
        issue_request(OP_APPEND, 8'd0, 32'sd1);
        issue_request(OP_INSERT, 8'd0, 32'sd2);
        issue_request(OP_READ, 8'd255, 32'sd0);
        issue_request(OP_WRITE, 8'd255, word_t'($urandom));
        issue_request(OP_READ, 8'd255, 32'sd0);
        for (int k = 0; k < 4; k++) issue_request(OP_DELETE, 8'd0, 32'sd0);
        issue_request(OP_INSERT, 8'd0, word_t'($urandom));
        issue_request(OP_READ, 8'd0, 32'sd0);
        issue_request(OP_READ, 8'd128, 32'sd0);
        wait_list_idle();
    endtask

    task automatic test_output_stall();
        idle_on = 1'b1;
        write_capacity(9'd64);
        hold_token++;
        issue_random_requests(30);
        wait_list_idle();
    endtask

    task automatic test_random_phases();
        count_t caps [6];
        caps = '{9'd256, 9'd1, 9'd2, 9'd0, 9'd511, 9'd17};
        for (int p = 0; p < 6; p++) begin
            idle_on = (p != 2);
            write_capacity(caps[p]);
            issue_random_requests(80);
        end
        write_capacity(count_t'($urandom_range(1, 256)));
        issue_random_requests(60);
        idle_on = 1'b0;
        write_capacity(CAP_RESET);
        issue_random_requests(80);
        wait_list_idle();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tvalid = 1'b0;
        cfg_data = '0;
        cfg_valid = 1'b0;
        cap_reg = CAP_RESET;
        list_count = 0;
        for (int i = 0; i < LIST_DEPTH; i++) list_mem[i] = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_basic_ops();
        test_capacity_corners();
        test_fill_to_depth();
        test_output_stall();
        test_random_phases();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
